// ===== rtl/anp_pkg.sv =====
// Shared constants, widths and stage payload types of the anchor pose blend unit.
// No dependencies; every other file in rtl/ imports this package.
package anp_pkg;

  // Output fixed-point format and blend fraction format
  localparam int FRAC_BITS = 16;
  localparam int T_SHIFT   = 16;
  localparam int T_W       = T_SHIFT + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_SHIFT;

  // Item kinds carried on tuser
  localparam logic ACT_ROT = 1'b0;
  localparam logic ACT_POS = 1'b1;

  // Lerp datapath widths
  localparam int COORD_W = 32;
  localparam int Q_W     = COORD_W + 1;     // lerp result, between a and c or -c
  localparam int D_W     = COORD_W + 2;     // difference c - a
  localparam int X_W     = D_W + T_W + 1;   // difference times t
  localparam int DOT_W   = 2 * COORD_W + 2; // exact 4-term dot product

  // Normalization widths
  localparam int MAG_W   = COORD_W;         // |q| <= 2^31
  localparam int POS_W   = $clog2(MAG_W);
  localparam int M_W     = 30;              // scaled magnitude in [2^29, 2^30)
  localparam int M_TOP   = M_W - 1;
  localparam int SUM_W   = 2 * M_W + 2;
  localparam int SQ_W    = 64;              // square root working width
  localparam int ISQRT_STEPS = SQ_W / 2;
  localparam int ROOT_W  = M_W + 2;
  localparam logic [ROOT_W-1:0] LEN_MIN = ROOT_W'(1) << M_TOP;

  // Divider widths
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int REM_W   = ROOT_W + FRAC_BITS + 1;

  // Per-item side information that rides along the pipeline from normalization to the result
  typedef struct packed {
    logic                    action;
    logic                    zero;
    logic [3:0]              sign;
    logic [3:0][COORD_W-1:0] qlow;
  } side_t;

  typedef struct packed {
    logic                action;
    logic [3:0][Q_W-1:0] q;
  } lerp_t;

  typedef struct packed {
    side_t               side;
    logic [3:0][M_W-1:0] m;
    logic [SUM_W-1:0]    sum;
  } norm_t;

  typedef struct packed {
    side_t               side;
    logic [3:0][M_W-1:0] m;
    logic [ROOT_W-1:0]   len;
  } root_t;

endpackage

// ===== rtl/anchor_pose_nlerp_unit.sv =====
// Top level of the anchor pose blend unit: stream ports, fraction register, pipeline.
// Depends on anp_pkg, anp_lerp, anp_norm, anp_isqrt and anp_div.
//
// Blends a bone anchor between the previous and the current pose at fraction t
// (cfg_wr_data, Q1.16, values above one saturate to one; reset value is one).
// tuser 0 is a rotation: the new quaternion is flipped onto the shortest arc,
// lerped and renormalized, giving identity when the lerp is all zero. tuser 1 is
// a position: x, y, z are lerped and w is zero. The unit takes one transaction
// per clock while no result is held, and every transaction gives exactly one result after
// 5 lerp stages, 4 scaling stages, 32 square root stages (one root bit each),
// the numerator stage, 17 divide stages (one quotient bit each) and the result
// register. The whole pipeline holds while a result waits on m_axis_tready.
module anchor_pose_nlerp_unit (
  input  logic                    clk,
  input  logic                    rst,
  // fraction register write
  input  logic                    cfg_wr_en,
  input  logic [anp_pkg::T_W-1:0] cfg_wr_data,
  // input transactions
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [255:0]            s_axis_tdata,  // old_x, old_y, old_z, old_w, new_x, new_y,
                                                 // new_z, new_w (32 bits each, from bit 0)
  input  logic                    s_axis_tuser,  // action
  // result transactions
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [127:0]            m_axis_tdata   // out_x, out_y, out_z, out_w (from bit 0)
);
  import anp_pkg::*;

  logic [T_W-1:0]          blend_fraction;
  logic                    ce;
  logic [3:0][COORD_W-1:0] old_c;
  logic [3:0][COORD_W-1:0] new_c;
  logic                    lerp_v, norm_v, root_v;
  lerp_t                   lerp_d;
  norm_t                   norm_d;
  root_t                   root_d;
  logic [3:0][COORD_W-1:0] out_comp;

  // fraction register
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_fraction <= T_ONE;
    end else if (cfg_wr_en) begin
      blend_fraction <= cfg_wr_data;
    end
  end

  // pipeline advances unless a result is held
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      old_c[i] = s_axis_tdata[COORD_W*i +: COORD_W];
      new_c[i] = s_axis_tdata[COORD_W*(i+4) +: COORD_W];
    end
  end

  anp_lerp u_lerp (
    .clk           (clk),
    .rst           (rst),
    .ce            (ce),
    .in_valid      (s_axis_tvalid),
    .action        (s_axis_tuser),
    .old_c         (old_c),
    .new_c         (new_c),
    .blend_fraction(blend_fraction),
    .out_valid     (lerp_v),
    .out_data      (lerp_d)
  );

  anp_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (lerp_v),
    .in_data  (lerp_d),
    .out_valid(norm_v),
    .out_data (norm_d)
  );

  anp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (norm_v),
    .in_data  (norm_d),
    .out_valid(root_v),
    .out_data (root_d)
  );

  anp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (root_v),
    .in_data  (root_d),
    .out_valid(m_axis_tvalid),
    .out_comp (out_comp)
  );

  assign m_axis_tdata = out_comp;

endmodule

// ===== rtl/anp_lerp.sv =====
// Five-stage lerp front end: input register, dot product, shortest-arc flip, scale, round.
// Depends on anp_pkg.
module anp_lerp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    ce,
  input  logic                                    in_valid,
  input  logic                                    action,
  input  logic [3:0][anp_pkg::COORD_W-1:0]        old_c,
  input  logic [3:0][anp_pkg::COORD_W-1:0]        new_c,
  input  logic [anp_pkg::T_W-1:0]                 blend_fraction,
  output logic                                    out_valid,
  output anp_pkg::lerp_t                          out_data
);
  import anp_pkg::*;

  logic [4:0] v_r;

  // stage 1: inputs and saturated fraction
  logic signed [COORD_W-1:0] a1 [4];
  logic signed [COORD_W-1:0] c1 [4];
  logic                      act1;
  logic [T_W-1:0]            t1;

  // stage 2: products and both candidate differences
  logic signed [2*COORD_W-1:0] prod2 [4];
  logic signed [D_W-1:0]       dpos2 [4];
  logic signed [D_W-1:0]       dneg2 [4];
  logic signed [COORD_W-1:0]   a2 [4];
  logic                        act2;
  logic [T_W-1:0]              t2;

  // stage 3: selected difference
  logic signed [DOT_W-1:0]   dot_next;
  logic                      flip_next;
  logic signed [D_W-1:0]     d3 [4];
  logic signed [COORD_W-1:0] a3 [4];
  logic                      act3;
  logic [T_W-1:0]            t3;

  // stage 4: scaled difference
  logic signed [X_W-1:0]     x4 [4];
  logic signed [COORD_W-1:0] a4 [4];
  logic                      act4;

  // stage 5: rounded lerp
  logic signed [X_W-1:0]     r_next [4];
  logic [3:0][Q_W-1:0]       q5;
  logic                      act5;

  assign dot_next = DOT_W'(prod2[0]) + DOT_W'(prod2[1]) + DOT_W'(prod2[2]) + DOT_W'(prod2[3]);
  assign flip_next = (act2 == ACT_ROT) && dot_next[DOT_W-1];

  // round half up: floor((x + 2^15) / 2^16)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r_next[i] = (x4[i] + (X_W'(1) <<< (T_SHIFT - 1))) >>> T_SHIFT;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ce) begin
      act1 <= action;
      t1   <= (blend_fraction > T_ONE) ? T_ONE : blend_fraction;
      act2 <= act1;
      t2   <= t1;
      act3 <= act2;
      t3   <= t2;
      act4 <= act3;
      act5 <= act4;
      for (int i = 0; i < 4; i++) begin
        a1[i]    <= $signed(old_c[i]);
        c1[i]    <= $signed(new_c[i]);
        prod2[i] <= a1[i] * c1[i];
        dpos2[i] <= D_W'(c1[i]) - D_W'(a1[i]);
        dneg2[i] <= -D_W'(c1[i]) - D_W'(a1[i]);
        a2[i]    <= a1[i];
        d3[i]    <= flip_next ? dneg2[i] : dpos2[i];
        a3[i]    <= a2[i];
        x4[i]    <= X_W'(d3[i]) * $signed({1'b0, t3});
        a4[i]    <= a3[i];
        if ((i == 3) && (act4 == ACT_POS)) begin
          q5[i] <= '0;
        end else begin
          q5[i] <= Q_W'(X_W'(a4[i]) + r_next[i]);
        end
      end
    end
  end

  assign out_valid       = v_r[4];
  assign out_data.action = act5;
  assign out_data.q      = q5;

endmodule

// ===== rtl/anp_norm.sv =====
// Four-stage magnitude scaling: abs and leading-one search, shift, squares, sum.
// Depends on anp_pkg.
module anp_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  anp_pkg::lerp_t in_data,
  output logic           out_valid,
  output anp_pkg::norm_t out_data
);
  import anp_pkg::*;

  logic [3:0] v_r;

  logic [3:0][MAG_W-1:0] mag_next;
  logic [MAG_W-1:0]      orv_next;
  logic [POS_W-1:0]      lead_next;

  logic [3:0][MAG_W-1:0] mag1;
  logic [POS_W-1:0]      lead1;
  side_t                 side1, side2, side3, side4;
  logic [3:0][M_W-1:0]   m2, m3, m4;
  logic [2*M_W-1:0]      sq3 [4];
  logic [SUM_W-1:0]      sum4;

  // magnitudes and the leading one of the largest
  always_comb begin
    orv_next  = '0;
    lead_next = '0;
    for (int i = 0; i < 4; i++) begin
      mag_next[i] = in_data.q[i][Q_W-1] ? MAG_W'(-in_data.q[i]) : MAG_W'(in_data.q[i]);
      orv_next    = orv_next | mag_next[i];
    end
    for (int b = 0; b < MAG_W; b++) begin
      if (orv_next[b]) begin
        lead_next = POS_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side1.action <= in_data.action;
      side1.zero   <= (orv_next == '0);
      mag1         <= mag_next;
      lead1        <= lead_next;
      side2        <= side1;
      side3        <= side2;
      side4        <= side3;
      m3           <= m2;
      m4           <= m3;
      sum4 <= SUM_W'(sq3[0]) + SUM_W'(sq3[1]) + SUM_W'(sq3[2]) + SUM_W'(sq3[3]);
      for (int i = 0; i < 4; i++) begin
        side1.sign[i] <= in_data.q[i][Q_W-1];
        side1.qlow[i] <= in_data.q[i][COORD_W-1:0];
        // bring the largest magnitude into [2^29, 2^30), truncating on the right
        if (lead1 > POS_W'(M_TOP)) begin
          m2[i] <= M_W'(mag1[i] >> (lead1 - POS_W'(M_TOP)));
        end else begin
          m2[i] <= M_W'(mag1[i] << (POS_W'(M_TOP) - lead1));
        end
        sq3[i] <= m2[i] * m2[i];
      end
    end
  end

  assign out_valid     = v_r[3];
  assign out_data.side = side4;
  assign out_data.m    = m4;
  assign out_data.sum  = sum4;

endmodule

// ===== rtl/anp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on anp_pkg.
module anp_isqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  anp_pkg::norm_t in_data,
  output logic           out_valid,
  output anp_pkg::root_t out_data
);
  import anp_pkg::*;

  logic [ISQRT_STEPS-1:0] v_r;
  logic [SQ_W-1:0]        n_r    [ISQRT_STEPS];
  logic [SQ_W-1:0]        root_r [ISQRT_STEPS];
  logic [3:0][M_W-1:0]    m_r    [ISQRT_STEPS];
  side_t                  side_r [ISQRT_STEPS];

  logic [SQ_W-1:0] n_src    [ISQRT_STEPS];
  logic [SQ_W-1:0] root_src [ISQRT_STEPS];
  logic [SQ_W-1:0] bit_c    [ISQRT_STEPS];
  logic [SQ_W-1:0] trial_c  [ISQRT_STEPS];
  logic [SQ_W-1:0] n_next   [ISQRT_STEPS];
  logic [SQ_W-1:0] root_next[ISQRT_STEPS];

  // one compare-subtract per stage, bit walks down by powers of four
  always_comb begin
    for (int k = 0; k < ISQRT_STEPS; k++) begin
      if (k == 0) begin
        n_src[k]    = SQ_W'(in_data.sum);
        root_src[k] = '0;
      end else begin
        n_src[k]    = n_r[k-1];
        root_src[k] = root_r[k-1];
      end
      bit_c[k]   = SQ_W'(1) << (2 * (ISQRT_STEPS - 1 - k));
      trial_c[k] = root_src[k] + bit_c[k];
      if (n_src[k] >= trial_c[k]) begin
        n_next[k]    = n_src[k] - trial_c[k];
        root_next[k] = (root_src[k] >> 1) + bit_c[k];
      end else begin
        n_next[k]    = n_src[k];
        root_next[k] = root_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[ISQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < ISQRT_STEPS; k++) begin
        n_r[k]    <= n_next[k];
        root_r[k] <= root_next[k];
        if (k == 0) begin
          m_r[k]    <= in_data.m;
          side_r[k] <= in_data.side;
        end else begin
          m_r[k]    <= m_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_valid     = v_r[ISQRT_STEPS-1];
  assign out_data.side = side_r[ISQRT_STEPS-1];
  assign out_data.m    = m_r[ISQRT_STEPS-1];
  assign out_data.len  = root_r[ISQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/anp_div.sv =====
// Four-lane restoring divider (one quotient bit per stage) and the result register.
// Depends on anp_pkg.
module anp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             ce,
  input  logic                             in_valid,
  input  anp_pkg::root_t                   in_data,
  output logic                             out_valid,
  output logic [3:0][anp_pkg::COORD_W-1:0] out_comp
);
  import anp_pkg::*;

  localparam int LAST = QUO_W;

  logic [LAST:0]           v_r;
  logic [3:0][REM_W-1:0]   rem_r  [LAST+1];
  logic [3:0][QUO_W-1:0]   quo_r  [LAST+1];
  logic [ROOT_W-1:0]       len_r  [LAST+1];
  side_t                   side_r [LAST+1];

  logic [REM_W-1:0]        dvs_c  [LAST+1];
  logic [3:0][REM_W-1:0]   rem_next [LAST+1];
  logic [3:0][QUO_W-1:0]   quo_next [LAST+1];

  logic                    out_v;
  logic [3:0][COORD_W-1:0] res_r;
  logic [3:0][COORD_W-1:0] res_next;
  side_t                   fin;

  // stage 0 forms the rounded numerator, stages 1..QUO_W take one bit each
  always_comb begin
    for (int j = 0; j <= LAST; j++) begin
      dvs_c[j] = '0;
      if (j == 0) begin
        for (int i = 0; i < 4; i++) begin
          rem_next[j][i] = (REM_W'(in_data.m[i]) << FRAC_BITS) + REM_W'(in_data.len >> 1);
          quo_next[j][i] = '0;
        end
      end else begin
        dvs_c[j] = REM_W'(len_r[j-1]) << (LAST - j);
        for (int i = 0; i < 4; i++) begin
          quo_next[j][i] = quo_r[j-1][i];
          if (rem_r[j-1][i] >= dvs_c[j]) begin
            rem_next[j][i]              = rem_r[j-1][i] - dvs_c[j];
            quo_next[j][i][LAST - j]    = 1'b1;
          end else begin
            rem_next[j][i] = rem_r[j-1][i];
          end
        end
      end
    end
  end

  // sign, identity and position selection
  assign fin = side_r[LAST];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fin.action == ACT_POS) begin
        res_next[i] = fin.qlow[i];
      end else if (fin.zero) begin
        res_next[i] = (i == 3) ? (COORD_W'(1) << FRAC_BITS) : '0;
      end else if (fin.sign[i]) begin
        res_next[i] = -COORD_W'(quo_r[LAST][i]);
      end else begin
        res_next[i] = COORD_W'(quo_r[LAST][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r   <= '0;
      out_v <= 1'b0;
    end else if (ce) begin
      v_r   <= {v_r[LAST-1:0], in_valid};
      out_v <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_next;
      for (int j = 0; j <= LAST; j++) begin
        rem_r[j] <= rem_next[j];
        quo_r[j] <= quo_next[j];
        if (j == 0) begin
          len_r[j]  <= in_data.len;
          side_r[j] <= in_data.side;
        end else begin
          len_r[j]  <= len_r[j-1];
          side_r[j] <= side_r[j-1];
        end
      end
    end
  end

  assign out_valid = out_v;
  assign out_comp  = res_r;

  // a nonzero rotation has its largest scaled magnitude at 2^29 or above, so its length is too
  a_len_floor: assert property (@(posedge clk) disable iff (rst)
    (v_r[LAST] && (fin.action == ACT_ROT) && !fin.zero) |-> (len_r[LAST] >= LEN_MIN))
    else $error("normalization length below scaled floor");

  // remainders end below the divisor
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (v_r[LAST] && (fin.action == ACT_ROT) && !fin.zero) |->
      ((rem_r[LAST][0] < REM_W'(len_r[LAST])) && (rem_r[LAST][1] < REM_W'(len_r[LAST])) &&
       (rem_r[LAST][2] < REM_W'(len_r[LAST])) && (rem_r[LAST][3] < REM_W'(len_r[LAST]))))
    else $error("divider remainder not reduced");

  // normalized components never exceed one
  a_quo_unit: assert property (@(posedge clk) disable iff (rst)
    (v_r[LAST] && (fin.action == ACT_ROT) && !fin.zero) |->
      ((quo_r[LAST][0] <= (QUO_W'(1) << FRAC_BITS)) &&
       (quo_r[LAST][1] <= (QUO_W'(1) << FRAC_BITS)) &&
       (quo_r[LAST][2] <= (QUO_W'(1) << FRAC_BITS)) &&
       (quo_r[LAST][3] <= (QUO_W'(1) << FRAC_BITS))))
    else $error("normalized component above one");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(res_r))
    else $error("result changed while stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for anchor_pose_nlerp_unit: fixed-point pose and quaternion blends.
// Depends on anp_pkg and the RTL of the unit; a bit-exact predictor computes every result.
module tb_top;
  import anp_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  logic [T_W-1:0] cfg_wr_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  logic [127:0] blend_q[$];
  logic [T_W-1:0] fraction;
  int  fail_count;
  int  match_count;
  int  sent_count;
  int  rot_count;
  int  pos_count;
  int  src_idle_pct;
  int  snk_stall_pct;
  longint cycle_count;

  anchor_pose_nlerp_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("timeout with %0d results outstanding", blend_q.size());
        $display("** anchor_pose_nlerp_unit: FAILED **");
        $finish;
      end
    end
  end

  // a + round((b - a) * t), halves toward +inf
  function automatic longint lerp_fix(longint a, longint b, longint t);
    longint x;
    x = (b - a) * t + 64'sd32768;
    return a + (x >>> 16);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned root, bits;
    root = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits >>= 2;
    while (bits != 0) begin
      if (n >= root + bits) begin
        n -= root + bits;
        root = (root >> 1) + bits;
      end else begin
        root >>= 1;
      end
      bits >>= 2;
    end
    return root;
  endfunction

  function automatic logic [127:0] predict_blend(logic act, logic [255:0] d);
    longint a[4], c[4], q[4];
    longint unsigned m[4], big, sum, len, r;
    longint t;
    logic signed [71:0] dot;
    logic [127:0] res;
    bit flip;
    t = (fraction > T_ONE) ? longint'(T_ONE) : longint'(fraction);
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(d[32*i +: 32]));
      c[i] = longint'($signed(d[128 + 32*i +: 32]));
    end
    if (act == ACT_POS) begin
      for (int i = 0; i < 3; i++) q[i] = lerp_fix(a[i], c[i], t);
      q[3] = 0;
    end else begin
      dot = 0;
      for (int i = 0; i < 4; i++) dot += 72'(a[i]) * 72'(c[i]);
      flip = dot < 0;
      big = 0;
      for (int i = 0; i < 4; i++) begin
        q[i] = lerp_fix(a[i], flip ? -c[i] : c[i], t);
        m[i] = (q[i] < 0) ? longint'(-q[i]) : q[i];
        if (m[i] > big) big = m[i];
      end
      if (big == 0) begin
        q[0] = 0; q[1] = 0; q[2] = 0;
        q[3] = 64'd1 << FRAC_BITS;
      end else begin
        while (big >= (64'd1 << 30)) begin
          big >>= 1;
          for (int i = 0; i < 4; i++) m[i] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
          big <<= 1;
          for (int i = 0; i < 4; i++) m[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum += m[i] * m[i];
        len = root_floor(sum);
        for (int i = 0; i < 4; i++) begin
          r = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
          q[i] = (q[i] < 0) ? -longint'(r) : longint'(r);
        end
      end
    end
    for (int i = 0; i < 4; i++) res[32*i +: 32] = q[i][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  // Result checker and receiver stalls
  initial begin
    logic [127:0] want;
    string names[4];
    names = '{"out_x", "out_y", "out_z", "out_w"};
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (blend_q.size() == 0) begin
          fail_count++;
          $display("unexpected result transaction at cycle %0d", cycle_count);
        end else begin
          want = blend_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32])
              report_mismatch(names[i], m_axis_tdata[32*i +: 32], want[32*i +: 32]);
            match_count++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Send one item, with random idle cycles before it as set for the phase
  task automatic send_item(logic act, logic [255:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    blend_q.insert(blend_q.size(), predict_blend(act, d));
    if (act == ACT_ROT) rot_count++; else pos_count++;
    sent_count++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (blend_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_fraction(logic [T_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fraction = v;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(16)) - 8);
      3: return 32'($signed($urandom_range(262144)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  // Fraction extremes and special vectors
  task automatic test_directed();
    logic [255:0] d;
    write_fraction(T_ONE);
    send_item(ACT_ROT, '0);
    send_item(ACT_POS, '0);
    send_item(ACT_ROT, {8{32'h8000_0000}});
    send_item(ACT_ROT, {8{32'h7fff_ffff}});
    send_item(ACT_POS, {{4{32'h7fff_ffff}}, {4{32'h8000_0000}}});
    go_idle();
    write_fraction('0);
    send_item(ACT_ROT, {128'h0, 32'h0001_0000, 96'h0});
    send_item(ACT_POS, {{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
    // opposite quaternions: negative dot, flip
    send_item(ACT_ROT, {32'hffff_0000, 96'h0, 32'h0001_0000, 96'h0});
    go_idle();
    write_fraction(17'h8000);
    // opposite after flip lerps to zero only if no flip; here dot zero, no flip
    send_item(ACT_ROT, {32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 96'h0});
    // opposite quaternions: negative dot flips the new one, so the lerp does not cancel to zero
    send_item(ACT_ROT, {32'h0000_0001, 96'h0, 32'hffff_ffff, 96'h0});
    send_item(ACT_POS, {32'h1234, 32'h1, 32'hffff_ffff, 32'h5, 32'h0, 32'h2, 32'h1, 32'h7});
    send_item(ACT_ROT, {32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3});
    go_idle();
    write_fraction(17'h1ffff);
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 8; k++) d[32*k +: 32] = rand_coord();
      send_item(i[0], d);
    end
    go_idle();
    write_fraction(17'h10001);
    send_item(ACT_ROT, {8{32'h0000_4000}});
    go_idle();
  endtask

  // Random items in one idling phase
  task automatic test_random(int n, int idle_pct, int stall_pct);
    logic [255:0] d;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) begin
        go_idle();
        case ($urandom_range(3))
          0: write_fraction('0);
          1: write_fraction(T_ONE);
          2: write_fraction(17'($urandom_range(131071)));
          default: write_fraction(17'($urandom_range(65536)));
        endcase
      end
      for (int k = 0; k < 8; k++) d[32*k +: 32] = rand_coord();
      send_item(1'($urandom_range(1)), d);
    end
    go_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_ROT;
    fraction = T_ONE;
    fail_count = 0;
    match_count = 0;
    sent_count = 0;
    rot_count = 0;
    pos_count = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(300, 86, 0);
    test_random(300, 0, 86);
    test_random(400, 34, 34);
    $display("covered %0d transactions (%0d rotation, %0d position), %0d results checked",
             sent_count, rot_count, pos_count, match_count);
    $display("fraction extremes, saturation, flips, zero-length identity and four idling mixes");
    if (fail_count == 0 && blend_q.size() == 0) begin
      $display("** anchor_pose_nlerp_unit: PASSED **");
    end else begin
      $display("** anchor_pose_nlerp_unit: FAILED **");
    end
    $finish;
  end
endmodule
